>>> design/sci_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the identifier scanner.
// No dependencies; imported by every other file of the block except sci_if.
package sci_pkg;

    localparam int MAX_TOKEN = 128;
    localparam int RUN_W     = $clog2(MAX_TOKEN + 1);

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_UNDER     = 8'h5F;

    typedef enum logic [0:0] {
        REG_MIN_LENGTH       = 1'b0,
        REG_PARSE_DIRECTIVES = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_CODE      = 3'd0,
        MODE_SLASH     = 3'd1,
        MODE_COMMENT   = 3'd2,
        MODE_STAR      = 3'd3,
        MODE_DQUOTE    = 3'd4,
        MODE_SQUOTE    = 3'd5,
        MODE_DIRECTIVE = 3'd6
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       ident_char;
        logic       token_done;
        logic [7:0] token_length;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
    endfunction

endpackage

>>> design/sci_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for source items and scan results.
// Depends on nothing; carries the payload fields of each item.
interface sci_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_file;

    modport source (output valid, output src_byte, output end_of_file, input ready);
    modport sink   (input valid, input src_byte, input end_of_file, output ready);
endinterface

interface sci_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] echo_byte;
    logic       ident_char;
    logic       token_done;
    logic [7:0] token_length;

    modport source (output valid, output echo_byte, output ident_char,
                    output token_done, output token_length, input ready);
    modport sink   (input valid, input echo_byte, input ident_char,
                    input token_done, input token_length, output ready);
endinterface

>>> design/sci_scan_core.sv
`timescale 1ns / 1ps
// Lexer state machine, run tracking and configuration registers.
// Depends on sci_pkg; produces one result per registered item.
module sci_scan_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [7:0]      cfg_wdata,
    input  logic            advance,
    input  sci_pkg::item_t  item,
    output sci_pkg::result_t result
);
    import sci_pkg::*;

    logic [7:0]       min_length_reg;
    logic             parse_dir_reg;
    lex_mode_t        mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             first_digit_reg, first_digit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= 8'd7;
            parse_dir_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_LENGTH:       min_length_reg <= cfg_wdata;
                REG_PARSE_DIRECTIVES: parse_dir_reg  <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_CODE;
            esc_reg         <= 1'b0;
            run_reg         <= '0;
            first_digit_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            esc_reg         <= esc_next;
            run_reg         <= run_next;
            first_digit_reg <= first_digit_next;
        end
    end

    always_comb
    begin
        logic [7:0] c;
        logic [7:0] close_ch;
        logic       as_code;
        c                = item.src_byte;
        mode_next        = mode_reg;
        esc_next         = esc_reg;
        run_next         = run_reg;
        first_digit_next = first_digit_reg;
        as_code          = 1'b0;
        close_ch         = CH_NEWLINE;
        result           = '0;

        if (item.end_of_file)
        begin
            mode_next        = MODE_CODE;
            esc_next         = 1'b0;
            run_next         = '0;
            first_digit_next = 1'b0;
        end
        else
        begin
            result.echo_byte = c;
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (c == CH_STAR)
                        mode_next = MODE_COMMENT;
                    else
                    begin
                        mode_next = MODE_CODE;
                        as_code   = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_CODE;
                    else if (c != CH_STAR)
                        mode_next = MODE_COMMENT;
                end
                MODE_DQUOTE, MODE_SQUOTE, MODE_DIRECTIVE:
                begin
                    if (mode_reg == MODE_DQUOTE)
                        close_ch = CH_DQUOTE;
                    else if (mode_reg == MODE_SQUOTE)
                        close_ch = CH_SQUOTE;
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (c == CH_BACKSLASH)
                        esc_next = 1'b1;
                    else if (c == close_ch)
                        mode_next = MODE_CODE;
                end
                default:
                begin
                    mode_next = MODE_CODE;
                    as_code   = 1'b1;
                end
            endcase

            if (as_code)
            begin
                if (is_ident(c))
                begin
                    // past MAX_TOKEN the run continues but bytes are dropped
                    if (32'(run_reg) < MAX_TOKEN)
                    begin
                        if (run_reg == '0)
                            first_digit_next = is_digit(c);
                        run_next          = run_reg + 1'b1;
                        result.ident_char = 1'b1;
                    end
                end
                else
                begin
                    if (run_reg != '0)
                    begin
                        if ((32'(run_reg) >= 32'(min_length_reg)) && !first_digit_reg)
                        begin
                            result.token_done   = 1'b1;
                            result.token_length = (32'(run_reg) > 32'd255) ?
                                                  8'hFF : 8'(run_reg);
                        end
                        run_next         = '0;
                        first_digit_next = 1'b0;
                    end
                    priority if (c == CH_DQUOTE)
                        mode_next = MODE_DQUOTE;
                    else if (c == CH_SQUOTE)
                        mode_next = MODE_SQUOTE;
                    else if (c == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else if ((c == CH_HASH) && !parse_dir_reg)
                        mode_next = MODE_DIRECTIVE;
                    else
                        mode_next = MODE_CODE;
                end
            end
        end
    end

endmodule

>>> design/sci_out_stage.sv
`timescale 1ns / 1ps
// Result register driving the output channel.
// Depends on sci_pkg and sci_res_if.
module sci_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sci_pkg::result_t result,
    output logic             can_load,
    sci_res_if.source        res
);
    import sci_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign res.valid        = valid_reg;
    assign res.echo_byte    = data_reg.echo_byte;
    assign res.ident_char   = data_reg.ident_char;
    assign res.token_done   = data_reg.token_done;
    assign res.token_length = data_reg.token_length;

endmodule

>>> design/c_source_identifier_scanner.sv
`timescale 1ns / 1ps
// C source identifier scanner. Takes one source byte per item and returns one result per
// item, marking identifier characters in plain code and flagging the byte after a run
// that qualifies (length >= min_length, not starting with a digit). Sustained rate is one
// item per clock while the result channel is ready; an accepted item goes from the input
// register through the lexer update into the result register. The user writes configuration
// (index 0 min_length, index 1 parse_directives) only while idle; the block does not check.
// Depends on sci_pkg, sci_if, sci_scan_core and sci_out_stage.
module c_source_identifier_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    sci_src_if.sink    src,
    sci_res_if.source  res
);
    import sci_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    result_t result;
    logic    can_load;
    logic    advance;

    assign advance   = in_valid_reg && can_load;
    assign src.ready = !in_valid_reg || can_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (src.valid && src.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            in_item_reg.src_byte    <= src.src_byte;
            in_item_reg.end_of_file <= src.end_of_file;
        end
    end

    sci_scan_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    sci_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

endmodule

>>> design/sci_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the scanner's result channel, bound to the top level.
// Depends on sci_pkg and c_source_identifier_scanner.
module sci_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] echo_byte,
    input logic       ident_char,
    input logic       token_done,
    input logic [7:0] token_length
);
    import sci_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(echo_byte) && $stable(token_done))
        else $error("result changed while stalled");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !token_done |-> token_length == 8'd0)
        else $error("length without token end");

    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid && token_done |-> token_length != 8'd0 && !ident_char)
        else $error("bad token end");

    a_kept_ident: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ident_char |-> is_ident(echo_byte))
        else $error("kept byte is not an identifier char");

    a_end_not_ident: assert property (@(posedge clk) disable iff (!rst_n)
        valid && token_done |-> !is_ident(echo_byte))
        else $error("token ended by an identifier char");

endmodule

bind c_source_identifier_scanner sci_checker u_sci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (res.valid),
    .ready        (res.ready),
    .echo_byte    (res.echo_byte),
    .ident_char   (res.ident_char),
    .token_done   (res.token_done),
    .token_length (res.token_length)
);

>>> tb/scan_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the identifier scanner: follows the config port and both channels,
// predicts one result per accepted item and compares in order.
// Depends on sci_pkg and sci_if.
module scan_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    sci_src_if         src,
    sci_res_if         res,
    output int         mismatches,
    output int         outstanding
);
    import sci_pkg::*;

    localparam logic [7:0] DEFAULT_MIN_LEN = 8'd7;

    // shadow configuration
    logic [7:0]  min_len_q;
    logic        parse_dir_q;

    // shadow scanner state
    lex_mode_t   mode_q;
    logic        esc_q;
    int unsigned run_q;
    logic        lead_digit_q;

    result_t     scan_results[$];
    int          errs;

    function automatic logic numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    endfunction

    task automatic clear_scan();
        mode_q       = MODE_CODE;
        esc_q        = 1'b0;
        run_q        = 0;
        lead_digit_q = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic eof, output result_t r);
        logic       as_code;
        logic [7:0] closer;
        r       = '0;
        as_code = 1'b0;
        if (eof)
        begin
            // pending run is dropped silently
            clear_scan();
        end
        else
        begin
            case (mode_q)
                MODE_SLASH:
                begin
                    if (c == CH_STAR)
                        mode_q = MODE_COMMENT;
                    else
                    begin
                        mode_q  = MODE_CODE;
                        as_code = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_STAR)
                        mode_q = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (c == CH_SLASH)
                        mode_q = MODE_CODE;
                    else if (c != CH_STAR)
                        mode_q = MODE_COMMENT;
                end
                MODE_DQUOTE, MODE_SQUOTE, MODE_DIRECTIVE:
                begin
                    if (esc_q)
                        esc_q = 1'b0;
                    else if (c == CH_BACKSLASH)
                        esc_q = 1'b1;
                    else
                    begin
                        closer = (mode_q == MODE_DQUOTE) ? CH_DQUOTE :
                                 (mode_q == MODE_SQUOTE) ? CH_SQUOTE : CH_NEWLINE;
                        if (c == closer)
                            mode_q = MODE_CODE;
                    end
                end
                default:
                begin
                    mode_q  = MODE_CODE;
                    as_code = 1'b1;
                end
            endcase

            if (as_code)
            begin
                if (name_char(c))
                begin
                    // past MAX_TOKEN the run goes on but nothing is kept
                    if (run_q < MAX_TOKEN)
                    begin
                        if (run_q == 0)
                            lead_digit_q = numeral(c);
                        run_q++;
                        r.ident_char = 1'b1;
                    end
                end
                else
                begin
                    if (run_q > 0)
                    begin
                        if (run_q >= min_len_q && !lead_digit_q)
                        begin
                            r.token_done   = 1'b1;
                            r.token_length = (run_q > 255) ? 8'd255 : run_q[7:0];
                        end
                        run_q        = 0;
                        lead_digit_q = 1'b0;
                    end
                    // the ending byte itself may open a literal, comment or directive
                    if (c == CH_DQUOTE)
                        mode_q = MODE_DQUOTE;
                    else if (c == CH_SQUOTE)
                        mode_q = MODE_SQUOTE;
                    else if (c == CH_SLASH)
                        mode_q = MODE_SLASH;
                    else if (c == CH_HASH && !parse_dir_q)
                        mode_q = MODE_DIRECTIVE;
                end
            end
            r.echo_byte = c;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        result_t nxt;
        if (!rst_n)
        begin
            scan_results.delete();
            min_len_q   = DEFAULT_MIN_LEN;
            parse_dir_q = 1'b0;
            clear_scan();
            errs        = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got.echo_byte    = res.echo_byte;
                got.ident_char   = res.ident_char;
                got.token_done   = res.token_done;
                got.token_length = res.token_length;
                if (scan_results.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("scan: unexpected result echo=%02h ident=%0b done=%0b len=%0d",
                                 got.echo_byte, got.ident_char, got.token_done,
                                 got.token_length);
                end
                else
                begin
                    want = scan_results.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"scan: mismatch exp echo=%02h ident=%0b done=%0b len=%0d",
                                      " | got echo=%02h ident=%0b done=%0b len=%0d"},
                                     want.echo_byte, want.ident_char, want.token_done,
                                     want.token_length, got.echo_byte, got.ident_char,
                                     got.token_done, got.token_length);
                    end
                end
            end
            if (src.valid && src.ready)
            begin
                scan_byte(src.src_byte, src.end_of_file, nxt);
                scan_results.push_back(nxt);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_MIN_LENGTH)
                    min_len_q = cfg_wdata;
                else
                    parse_dir_q = cfg_wdata[0];
            end
            mismatches  <= errs;
            outstanding <= scan_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the identifier scanner bench: clock, reset, config phases, C-like source
// stimulus and result back-pressure; verdict from scan_checker.
// Depends on sci_pkg, sci_if, c_source_identifier_scanner and scan_checker.
module tb_top;
    import sci_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_BUDGET = 1100;
    localparam int PHASES      = 7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;
    logic       steady    = 1'b0;   // no idling on either side while set

    int bytes_sent   = 0;
    int quiet_cycles = 0;
    int fail_total;
    int in_flight;

    sci_src_if src_ch ();
    sci_res_if res_ch ();

    c_source_identifier_scanner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .src       (src_ch),
        .res       (res_ch)
    );

    scan_checker u_scan_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .src         (src_ch),
        .res         (res_ch),
        .mismatches  (fail_total),
        .outstanding (in_flight)
    );

    always #10 clk = ~clk;

    // result back-pressure
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!steady && $urandom_range(99) < 22)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.src_byte    <= b;
        src_ch.end_of_file <= eof;
        do
            @(posedge clk);
        while (!src_ch.ready);
        bytes_sent++;
    endtask

    task automatic emit_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_name_char(input logic letter_only);
        int k;
        k = letter_only ? $urandom_range(51) : $urandom_range(62);
        if (k < 26)
            return 8'h61 + k[7:0];
        else if (k < 52)
            return 8'h41 + k[7:0] - 8'd26;
        else if (k < 62)
            return 8'h30 + k[7:0] - 8'd52;
        else
            return CH_UNDER;
    endfunction

    // body bytes for comments, literals and directives, biased to the tricky ones
    function automatic logic [7:0] rand_filler();
        case ($urandom_range(9))
            0, 1:    return CH_STAR;
            2:       return CH_SLASH;
            3:       return CH_BACKSLASH;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            6:       return CH_NEWLINE;
            default: return rand_name_char(1'b0);
        endcase
    endfunction

    task automatic emit_name(input int n, input logic letter_first);
        send_byte(rand_name_char(letter_first), 1'b0);
        for (int i = 1; i < n; i++)
            send_byte(rand_name_char(1'b0), 1'b0);
    endtask

    task automatic emit_separator();
        string seps;
        seps = " \n\t;(),+-=<>{}[]!&|~^%?:.";
        send_byte(seps[$urandom_range(seps.len() - 1)], 1'b0);
    endtask

    task automatic emit_fragment();
        int         kind;
        int         n;
        logic [7:0] c;
        kind = $urandom_range(99);
        n    = $urandom_range(8);
        if (kind < 30)
            emit_name($urandom_range(1, 12), $urandom_range(4) != 0);
        else if (kind < 44)
            repeat ($urandom_range(1, 3)) emit_separator();
        else if (kind < 53)
        begin
            emit_text("/*");
            repeat (n) send_byte(rand_filler(), 1'b0);
            emit_text("*/");
        end
        else if (kind < 61)
        begin
            send_byte(CH_DQUOTE, 1'b0);
            repeat (n)
            begin
                c = rand_filler();
                if (c == CH_DQUOTE)
                    c = 8'h20;
                send_byte(c, 1'b0);
                if (c == CH_BACKSLASH)
                    send_byte(8'($urandom_range(255)), 1'b0);
            end
            send_byte(CH_DQUOTE, 1'b0);
        end
        else if (kind < 67)
        begin
            send_byte(CH_SQUOTE, 1'b0);
            if ($urandom_range(1))
            begin
                send_byte(CH_BACKSLASH, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            else
                send_byte(rand_name_char(1'b0), 1'b0);
            send_byte(CH_SQUOTE, 1'b0);
        end
        else if (kind < 75)
        begin
            // directive; embedded newlines get a line continuation
            send_byte(CH_HASH, 1'b0);
            repeat (n)
            begin
                c = rand_filler();
                if (c == CH_NEWLINE)
                    send_byte(CH_BACKSLASH, 1'b0);
                send_byte(c, 1'b0);
                if (c == CH_BACKSLASH)
                    send_byte(8'($urandom_range(255)), 1'b0);
            end
            send_byte(CH_NEWLINE, 1'b0);
        end
        else if (kind < 78)
        begin
            emit_text("//");
            emit_name($urandom_range(1, 9), 1'b1);
        end
        else if (kind < 81)
        begin
            send_byte(CH_SLASH, 1'b0);
            send_byte(rand_name_char(1'b0), 1'b0);
        end
        else if (kind < 96)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
        else if (kind < 99)
            send_byte(8'($urandom_range(255)), 1'b1);
        else
            emit_name($urandom_range(120, 140), 1'b1);
    endtask

    // sender holds off until every result is back
    task automatic drain_results();
        src_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    task automatic apply_settings(input logic [7:0] min_len, input logic dir_on);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_LENGTH;
        cfg_wdata <= min_len;
        @(posedge clk);
        cfg_index <= REG_PARSE_DIRECTIVES;
        cfg_wdata <= {7'd0, dir_on};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         goal;
        logic [7:0] min_len;
        logic       dir_on;
        src_ch.valid       = 1'b0;
        src_ch.src_byte    = '0;
        src_ch.end_of_file = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: run ended by slash, slash then code, hash mid-line,
        // escaped newline in a directive, escaped quote, "//", high byte, run cut by EOF
        emit_text("Abc_xyz9/x#\\\n\n'\\''//");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h00, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin min_len = 8'd0;   dir_on = 1'b1; end
                1:       begin min_len = 8'd1;   dir_on = 1'b0; end
                2:       begin min_len = 8'd255; dir_on = 1'b0; end
                3:       begin min_len = 8'd129; dir_on = 1'b1; end
                4:       begin min_len = 8'd128; dir_on = 1'b0; end
                default:
                begin
                    min_len = 8'($urandom_range(2, 12));
                    dir_on  = 1'($urandom_range(1));
                end
            endcase
            drain_results();
            apply_settings(min_len, dir_on);
            steady <= (p == 1);
            goal = bytes_sent + (ITEM_BUDGET - bytes_sent) / (PHASES - p);
            if (p == 3 || p == 4)
            begin
                // exactly at the cap, then past it
                emit_name(MAX_TOKEN, 1'b1);
                emit_separator();
                emit_name(MAX_TOKEN + 7, 1'b1);
                emit_separator();
            end
            while (bytes_sent < goal)
                emit_fragment();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_total == 0 && in_flight == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
design/sci_pkg.sv
design/sci_if.sv
design/sci_scan_core.sv
design/sci_out_stage.sv
design/c_source_identifier_scanner.sv
design/sci_checker.sv
tb/scan_checker.sv
tb/tb_top.sv
